// File: sv/cpms_pkg.sv
package cpms_pkg;

  // default capacity and coordinate width
  localparam int MaxPoints = 1024;
  localparam int CoordBits = 16;

  // fixed output widths and strip window depth
  localparam int DistBits  = 33;
  localparam int CheckBits = 20;
  localparam int WinDepth  = 4;

  // handshake from the sequencer into the strip checker
  typedef struct packed {
    logic clear;  // start of a new merge: empty the window
    logic visit;  // a merged point is offered
  } strip_ctl_t;

endpackage

// File: sv/cpms_strip.sv
// strip checker: one merged point at a time, one window slot per step,
// a single squaring multiplier shared by all tests
module cpms_strip #(
  parameter int CoordBits = cpms_pkg::CoordBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cpms_pkg::strip_ctl_t        ctl_i,
  input  logic signed [CoordBits-1:0] cx_i,
  input  logic signed [CoordBits-1:0] cy_i,
  input  logic signed [CoordBits-1:0] div_i,
  input  logic                        reset_best_i,
  output logic                        busy_o,
  output logic                        found_o,
  output logic [CoordBits-1:0]        fx_o,
  output logic [CoordBits-1:0]        fy_o,
  output logic [CoordBits-1:0]        sx_o,
  output logic [CoordBits-1:0]        sy_o,
  output logic [cpms_pkg::DistBits-1:0]  dist_o,
  output logic [cpms_pkg::CheckBits-1:0] checks_o
);
  localparam int DB = CoordBits + 1;      // difference width
  localparam int SB = 2 * DB;             // square width
  localparam int TB = SB + 1;             // sum width
  localparam int W  = cpms_pkg::WinDepth;
  localparam int KB = $clog2(W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STRIP = 3'd1;
  localparam logic [2:0] S_GAP = 3'd2;
  localparam logic [2:0] S_DX = 3'd3;
  localparam logic [2:0] S_DY = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0] st_q, st_d;
  logic signed [CoordBits-1:0] wx_q [W];
  logic signed [CoordBits-1:0] wy_q [W];
  logic [W-1:0] wok_q;
  logic [KB-1:0] k_q;      // slots visited, newest first
  logic [KB-1:0] keep_q;
  logic [TB-1:0] best_q;
  logic best_ok_q;
  logic [CoordBits-1:0] bfx_q, bfy_q, bsx_q, bsy_q;
  logic [cpms_pkg::CheckBits-1:0] chk_q;
  logic [SB-1:0] dxsq_q;
  logic signed [CoordBits-1:0] cx_q, cy_q, div_q;

  // current window slot, newest at W-1
  logic [$clog2(W)-1:0] slot;
  assign slot = $clog2(W)'(W - 1 - int'(k_q));

  // shared squaring unit
  logic signed [DB-1:0] mop;
  logic [DB-1:0] mabs;
  logic [SB-1:0] msq;
  always_comb begin
    case (st_q)
      S_STRIP: mop = DB'(cx_q) - DB'(div_q);
      S_GAP:   mop = DB'(cy_q) - DB'(wy_q[slot]);
      S_DX:    mop = DB'(cx_q) - DB'(wx_q[slot]);
      S_DY:    mop = DB'(cy_q) - DB'(wy_q[slot]);
      default: mop = '0;
    endcase
    mabs = mop[DB-1] ? DB'(-mop) : mop;
    msq  = SB'(mabs) * SB'(mabs);
  end

  logic below;
  logic [TB-1:0] dsum;
  logic signed [DB-1:0] oa, ob;
  logic opp;
  always_comb begin
    dsum  = TB'(dxsq_q) + TB'(msq);
    below = !best_ok_q || (TB'(msq) < best_q);
    oa = DB'(cx_q) - DB'(div_q);
    ob = DB'(wx_q[slot]) - DB'(div_q);
    opp = (oa == '0) || (ob == '0) || (oa[DB-1] != ob[DB-1]);
  end

  assign busy_o = (st_q != S_IDLE);

  // sequencer over the window
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (ctl_i.visit) st_d = S_STRIP;
      S_STRIP: st_d = below ? S_GAP : S_IDLE;
      S_GAP: begin
        if (k_q == KB'(W) || !wok_q[slot] || !(mop[DB-1] || below)) st_d = S_PUSH;
        else if (opp) st_d = S_DX;
        else st_d = S_GAP;
      end
      S_DX:    st_d = S_DY;
      S_DY:    st_d = S_GAP;
      S_PUSH:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      wok_q <= '0;
      best_q <= '1;
      best_ok_q <= 1'b0;
      chk_q <= '0;
      k_q <= '0;
      keep_q <= '0;
      bfx_q <= '0; bfy_q <= '0; bsx_q <= '0; bsy_q <= '0;
    end else begin
      st_q <= st_d;
      if (reset_best_i) begin
        best_q <= '1;
        best_ok_q <= 1'b0;
        chk_q <= '0;
        bfx_q <= '0; bfy_q <= '0; bsx_q <= '0; bsy_q <= '0;
      end
      if (ctl_i.clear) wok_q <= '0;
      case (st_q)
        S_IDLE: begin
          if (ctl_i.visit) begin
            cx_q <= cx_i; cy_q <= cy_i; div_q <= div_i;
            k_q <= '0; keep_q <= '0;
          end
        end
        S_GAP: begin
          if (st_d == S_GAP) begin
            k_q <= k_q + 1'b1; keep_q <= keep_q + 1'b1;
          end
        end
        S_DX: dxsq_q <= msq;
        S_DY: begin
          if (chk_q != '1) chk_q <= chk_q + 1'b1;
          if (!best_ok_q || dsum < best_q) begin
            best_q <= dsum; best_ok_q <= 1'b1;
            bfx_q <= cx_q; bfy_q <= cy_q;
            bsx_q <= wx_q[slot]; bsy_q <= wy_q[slot];
          end
          k_q <= k_q + 1'b1; keep_q <= keep_q + 1'b1;
        end
        S_PUSH: begin
          // keep the newest entries, shift, push the current point
          for (int i = 0; i < W - 1; i++) begin
            wx_q[i] <= wx_q[i+1];
            wy_q[i] <= wy_q[i+1];
            wok_q[i] <= wok_q[i+1] && (i >= W - 1 - int'(keep_q));
          end
          wx_q[W-1] <= cx_q; wy_q[W-1] <= cy_q; wok_q[W-1] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign found_o  = best_ok_q;
  assign fx_o = bfx_q; assign fy_o = bfy_q;
  assign sx_o = bsx_q; assign sy_o = bsy_q;
  assign dist_o   = cpms_pkg::DistBits'(best_q);
  assign checks_o = chk_q;
endmodule

// File: sv/closest_pair_merge_strip_top.sv
// closest pair merge strip
// points come in on start/point_x_i/point_y_i/last_point_i, one transfer per
// cycle while busy is low, in nondecreasing x order. a point with last_point_i
// set starts a bottom-up merge sort on y; each merged point inside the strip
// around the merge divider is checked against up to four earlier strip points.
// the sort takes ceil(log2(N)) passes; a pass opens with a pass step, takes a
// group step per run pair and closes with one more group step. a merged point
// goes through read, select, visit, the strip checker's steps and a handover
// wait; a point copied from a lone tail run skips the visit. the strip
// checker's single squaring multiplier is the limit.
// when done, result_valid_o pulses for one cycle with the best pair, squared
// distance, check count and the drop flag. the receiver cannot stall, so the
// result is simply presented once. busy stays high from the last point through
// the cycle after that pulse. reset empties the block; after a result the point
// count, best pair and drop flag clear; excess points are dropped and flagged.
module closest_pair_merge_strip_top #(
  parameter int MaxPoints = cpms_pkg::MaxPoints,
  parameter int CoordBits = cpms_pkg::CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CoordBits-1:0] point_x_i,
  input  logic signed [CoordBits-1:0] point_y_i,
  input  logic                 last_point_i,
  output logic                 result_valid_o,
  output logic                 pair_found_o,
  output logic signed [CoordBits-1:0] first_x_o,
  output logic signed [CoordBits-1:0] first_y_o,
  output logic signed [CoordBits-1:0] second_x_o,
  output logic signed [CoordBits-1:0] second_y_o,
  output logic [cpms_pkg::DistBits-1:0]  best_distance_sq_o,
  output logic [cpms_pkg::CheckBits-1:0] distance_checks_o,
  output logic                 points_dropped_o
);
  localparam int AB = $clog2(MaxPoints);
  localparam int CB = AB + 1;
  localparam int PW = 2 * CoordBits;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_PASS = 4'd1;
  localparam logic [3:0] S_GRP = 4'd2;
  localparam logic [3:0] S_RD = 4'd3;
  localparam logic [3:0] S_WT = 4'd4;
  localparam logic [3:0] S_SEL = 4'd5;
  localparam logic [3:0] S_VIS = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;
  localparam logic [3:0] S_CLR = 4'd8;

  logic [3:0] st_q;
  logic [CB-1:0] n_q, g_q, st0_q, i_q, j_q, n1_q, n2_q, k_q;
  logic bank_q;   // 0: source is bank a
  logic drop_q;

  // memories
  logic [PW-1:0] bank_a [MaxPoints];
  logic [PW-1:0] bank_b [MaxPoints];
  logic [CoordBits-1:0] divs [MaxPoints];
  logic [PW-1:0] la_q, ra_q;
  logic [CoordBits-1:0] div_q;

  logic s_busy, found;
  logic [CoordBits-1:0] fx, fy, sx, sy;
  logic [cpms_pkg::DistBits-1:0] best_dsq;
  logic [cpms_pkg::CheckBits-1:0] chk;
  cpms_pkg::strip_ctl_t ctl;
  logic [PW-1:0] cur_q;

  logic take;
  assign take = start && !busy;
  assign busy = (st_q != S_LOAD);

  // read addresses of the two heads
  logic [CB-1:0] li, ri;
  assign li = st0_q + i_q;
  assign ri = st0_q + g_q + j_q;
  logic pick_l;
  assign pick_l = (j_q >= n2_q) ||
                  (i_q < n1_q && $signed(la_q[CoordBits-1:0]) <= $signed(ra_q[CoordBits-1:0]));

  logic [CB-1:0] rem;
  assign rem = n_q - (st0_q + g_q);

  always_ff @(posedge clk_i) begin
    if (take && n_q < CB'(MaxPoints)) begin
      bank_a[n_q[AB-1:0]] <= {point_x_i, point_y_i};
      divs[n_q[AB-1:0]] <= point_x_i;
    end
    if (st_q == S_RD) begin
      if (!bank_q) begin
        la_q <= bank_a[li[AB-1:0]]; ra_q <= bank_a[ri[AB-1:0]];
      end else begin
        la_q <= bank_b[li[AB-1:0]]; ra_q <= bank_b[ri[AB-1:0]];
      end
    end
    if (st_q == S_GRP && st0_q + g_q < n_q) div_q <= divs[AB'(st0_q + g_q)];
    if (st_q == S_SEL) begin
      if (!bank_q) bank_b[k_q[AB-1:0]] <= pick_l ? la_q : ra_q;
      else         bank_a[k_q[AB-1:0]] <= pick_l ? la_q : ra_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; n_q <= '0; drop_q <= 1'b0; bank_q <= 1'b0;
      g_q <= '0; st0_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0;
      n1_q <= '0; n2_q <= '0;
    end else begin
      case (st_q)
        S_LOAD: if (take) begin
          if (n_q < CB'(MaxPoints)) n_q <= n_q + 1'b1;
          else drop_q <= 1'b1;
          if (last_point_i) begin
            st_q <= S_PASS; g_q <= CB'(1); bank_q <= 1'b0;
          end
        end
        S_PASS: begin
          if (g_q >= n_q || g_q == '0) st_q <= S_OUT;
          else begin st0_q <= '0; st_q <= S_GRP; end
        end
        S_GRP: begin
          if (st0_q >= n_q) begin
            bank_q <= !bank_q; g_q <= g_q << 1; st_q <= S_PASS;
          end else begin
            // a lone tail run is merged with an empty right run
            n1_q <= (st0_q + g_q >= n_q) ? n_q - st0_q : g_q;
            n2_q <= (st0_q + g_q >= n_q) ? '0 : (rem < g_q ? rem : g_q);
            i_q <= '0; j_q <= '0; k_q <= st0_q;
            st_q <= S_RD;
          end
        end
        S_RD: st_q <= S_SEL;
        S_SEL: begin
          cur_q <= pick_l ? la_q : ra_q;
          if (pick_l) i_q <= i_q + 1'b1; else j_q <= j_q + 1'b1;
          k_q <= k_q + 1'b1;
          st_q <= (n2_q == '0) ? S_WT : S_VIS;
        end
        S_VIS: st_q <= S_WT;
        S_WT: if (!s_busy) begin
          if (i_q >= n1_q && j_q >= n2_q) begin
            st0_q <= st0_q + (g_q << 1); st_q <= S_GRP;
          end else st_q <= S_RD;
        end
        S_OUT: st_q <= S_CLR;
        S_CLR: begin
          st_q <= S_LOAD; n_q <= '0; drop_q <= 1'b0;
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  assign ctl.clear = (st_q == S_GRP);
  assign ctl.visit = (st_q == S_VIS);

  cpms_strip #(.CoordBits(CoordBits)) u_strip (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .cx_i(cur_q[PW-1:CoordBits]), .cy_i(cur_q[CoordBits-1:0]), .div_i(div_q),
    .reset_best_i(st_q == S_CLR), .busy_o(s_busy), .found_o(found),
    .fx_o(fx), .fy_o(fy), .sx_o(sx), .sy_o(sy), .dist_o(best_dsq), .checks_o(chk)
  );

  // result transfer
  assign result_valid_o     = (st_q == S_OUT);
  assign pair_found_o       = found;
  assign first_x_o          = fx;
  assign first_y_o          = fy;
  assign second_x_o         = sx;
  assign second_y_o         = sy;
  assign best_distance_sq_o = best_dsq;
  assign distance_checks_o  = chk;
  assign points_dropped_o   = drop_q;

  // a result is a single pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held");
  // no point is taken while sorting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_LOAD) |-> !take) else $error("take while busy");
  // no pair means no distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !pair_found_o) |-> (best_distance_sq_o == '1))
    else $error("distance without pair");
endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  localparam int CoordBits = cpms_pkg::CoordBits;
  localparam int MaxPoints = cpms_pkg::MaxPoints;
  localparam int DistBits  = cpms_pkg::DistBits;
  localparam int CheckBits = cpms_pkg::CheckBits;
  localparam int WinDepth  = cpms_pkg::WinDepth;

  localparam int IdleLimit = 600000;
  localparam int ChkMax    = (1 << CheckBits) - 1;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, known from time zero
  logic                        start = 1'b0;
  logic signed [CoordBits-1:0] point_x_i = '0;
  logic signed [CoordBits-1:0] point_y_i = '0;
  logic                        last_point_i = 1'b0;

  // block outputs
  logic                        busy;
  logic                        result_valid_o;
  logic                        pair_found_o;
  logic signed [CoordBits-1:0] first_x_o, first_y_o, second_x_o, second_y_o;
  logic [DistBits-1:0]         best_distance_sq_o;
  logic [CheckBits-1:0]        distance_checks_o;
  logic                        points_dropped_o;

  typedef struct {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    bit                          last;
  } point_in_t;

  typedef struct {
    logic                        found;
    logic signed [CoordBits-1:0] fx, fy, sx, sy;
    logic [DistBits-1:0]         dist_sq;
    logic [CheckBits-1:0]        checks;
    logic                        dropped;
  } pair_answer_t;

  typedef struct {
    longint x;
    longint y;
  } xy_t;

  point_in_t    point_queue[$];
  pair_answer_t expected_answers[$];
  int           n_total = 0;
  int           n_sent = 0;
  int           n_accepted = 0;
  int           n_mismatch = 0;
  int           idle_cycles = 0;
  bit           took = 1'b0;

  // predictor state
  xy_t             bank[2][MaxPoints];
  longint          dividers[MaxPoints];
  xy_t             win_pt[WinDepth];
  bit              win_ok[WinDepth];
  longint unsigned best_d;
  bit              best_v;
  xy_t             best_f, best_s;
  int              check_cnt;
  int              n_held;
  bit              drop_flag;

  closest_pair_merge_strip_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .last_point_i       (last_point_i),
    .result_valid_o     (result_valid_o),
    .pair_found_o       (pair_found_o),
    .first_x_o          (first_x_o),
    .first_y_o          (first_y_o),
    .second_x_o         (second_x_o),
    .second_y_o         (second_y_o),
    .best_distance_sq_o (best_distance_sq_o),
    .distance_checks_o  (distance_checks_o),
    .points_dropped_o   (points_dropped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned square(longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : d;
    return a * a;
  endfunction

  function automatic bit under_best(longint unsigned v);
    return !best_v || v < best_d;
  endfunction

  function automatic void clear_pair_state();
    foreach (win_ok[k]) begin
      win_ok[k] = 1'b0;
      win_pt[k] = '{0, 0};
    end
    best_d = 64'h3_FFFF_FFFF;
    best_v = 1'b0;
    best_f = '{0, 0};
    best_s = '{0, 0};
    check_cnt = 0;
    n_held = 0;
    drop_flag = 1'b0;
  endfunction

  // distance of one candidate pair
  function automatic void measure_pair(xy_t c, xy_t p);
    longint unsigned d;
    d = square(c.x - p.x) + square(c.y - p.y);
    if (check_cnt < ChkMax) check_cnt++;
    if (under_best(d)) begin
      best_d = d;
      best_v = 1'b1;
      best_f = c;
      best_s = p;
    end
  endfunction

  // strip test and window update for one merged point
  function automatic void scan_strip(xy_t c, longint dv);
    int     keep;
    bit     stop;
    longint a, b, dy;
    keep = 0;
    stop = 1'b0;
    if (!under_best(square(c.x - dv))) return;
    for (int k = WinDepth - 1; k >= 0; k--) begin
      if (!stop) begin
        dy = c.y - win_pt[k].y;
        if (!win_ok[k] || !(dy < 0 || under_best(square(dy)))) begin
          stop = 1'b1;
        end else begin
          a = c.x - dv;
          b = win_pt[k].x - dv;
          if (a == 0 || b == 0 || ((a < 0) != (b < 0))) measure_pair(c, win_pt[k]);
          keep++;
        end
      end
    end
    if (keep > WinDepth - 1) keep = WinDepth - 1;
    for (int k = 0; k < WinDepth - 1; k++) begin
      win_pt[k] = win_pt[k + 1];
      win_ok[k] = win_ok[k + 1] && (k >= WinDepth - 1 - keep);
    end
    win_pt[WinDepth - 1] = c;
    win_ok[WinDepth - 1] = 1'b1;
  endfunction

  function automatic void merge_on_y(int s, int lo, int n1, int n2, longint dv);
    int  i, j, k;
    xy_t c;
    i = 0;
    j = 0;
    k = lo;
    foreach (win_ok[w]) win_ok[w] = 1'b0;
    while (i < n1 || j < n2) begin
      if (j >= n2 || (i < n1 && bank[s][lo + i].y <= bank[s][lo + n1 + j].y)) begin
        c = bank[s][lo + i];
        i++;
      end else begin
        c = bank[s][lo + n1 + j];
        j++;
      end
      bank[1 - s][k] = c;
      k++;
      scan_strip(c, dv);
    end
  endfunction

  // take in one point; on the final one sort and return the answer
  function automatic bit take_point(point_in_t it, output pair_answer_t ans);
    int s, n, nx, n2;
    if (n_held < MaxPoints) begin
      bank[0][n_held] = '{longint'(it.x), longint'(it.y)};
      dividers[n_held] = longint'(it.x);
      n_held++;
    end else begin
      drop_flag = 1'b1;
    end
    if (!it.last) return 1'b0;
    s = 0;
    n = n_held;
    for (int g = 1; g < n; g <<= 1) begin
      for (int st = 0; st < n; st += 2 * g) begin
        nx = st + g;
        n2 = (nx >= n) ? 0 : ((n - nx < g) ? n - nx : g);
        if (n2 == 0) begin
          for (int q = st; q < n; q++) bank[1 - s][q] = bank[s][q];
        end else begin
          merge_on_y(s, st, g, n2, dividers[nx]);
        end
      end
      s = 1 - s;
    end
    ans.found   = best_v;
    ans.fx      = best_v ? best_f.x[CoordBits-1:0] : '0;
    ans.fy      = best_v ? best_f.y[CoordBits-1:0] : '0;
    ans.sx      = best_v ? best_s.x[CoordBits-1:0] : '0;
    ans.sy      = best_v ? best_s.y[CoordBits-1:0] : '0;
    ans.dist_sq = best_v ? best_d[DistBits-1:0] : '1;
    ans.checks  = check_cnt[CheckBits-1:0];
    ans.dropped = drop_flag;
    clear_pair_state();
    return 1'b1;
  endfunction

  // queue one point set; xs sorted unless scrambled
  task automatic add_set(int n, int lo_c, int hi_c, bit scramble);
    int xs[$];
    point_in_t it;
    for (int i = 0; i < n; i++) xs.push_back(int'($urandom_range(hi_c - lo_c)) + lo_c);
    if (!scramble) xs.sort();
    for (int i = 0; i < n; i++) begin
      it.x = CoordBits'(xs[i]);
      it.y = CoordBits'(int'($urandom_range(hi_c - lo_c)) + lo_c);
      it.last = (i == n - 1);
      point_queue.push_back(it);
    end
  endtask

  function automatic point_in_t mk(int x, int y, bit last);
    point_in_t it;
    it.x = CoordBits'(x);
    it.y = CoordBits'(y);
    it.last = last;
    return it;
  endfunction

  // driver: new transfer on the falling edge once the last one was taken
  always @(negedge clk_i) begin
    point_in_t it;
    if (rst_ni && (!start || took)) begin
      if (point_queue.size() > 0 &&
          ((n_sent >= 250 && n_sent < 400) || $urandom_range(99) >= 15)) begin
        it = point_queue.pop_front();
        start <= 1'b1;
        point_x_i <= it.x;
        point_y_i <= it.y;
        last_point_i <= it.last;
        n_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: accepted points feed the predictor, results are checked
  always @(posedge clk_i) begin
    pair_answer_t ans, exp_a;
    point_in_t    it;
    bit           act;
    act = 1'b0;
    if (rst_ni) begin
      took <= start && !busy;
      if (result_valid_o) begin
        act = 1'b1;
        if (expected_answers.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          exp_a = expected_answers.pop_front();
          if (pair_found_o !== exp_a.found || first_x_o !== exp_a.fx ||
              first_y_o !== exp_a.fy || second_x_o !== exp_a.sx ||
              second_y_o !== exp_a.sy || best_distance_sq_o !== exp_a.dist_sq ||
              distance_checks_o !== exp_a.checks || points_dropped_o !== exp_a.dropped) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  exp found=%0d first=(%0d,%0d) second=(%0d,%0d) d=%0d chk=%0d drop=%0d",
                       exp_a.found, exp_a.fx, exp_a.fy, exp_a.sx, exp_a.sy, exp_a.dist_sq,
                       exp_a.checks, exp_a.dropped);
              $display("  got found=%0d first=(%0d,%0d) second=(%0d,%0d) d=%0d chk=%0d drop=%0d",
                       pair_found_o, first_x_o, first_y_o, second_x_o, second_y_o,
                       best_distance_sq_o, distance_checks_o, points_dropped_o);
            end
          end
        end
      end
      if (start && !busy) begin
        act = 1'b1;
        it = mk(point_x_i, point_y_i, last_point_i);
        if (take_point(it, ans)) expected_answers.push_back(ans);
        n_accepted++;
      end
      // watchdog on cycles without any transfer
      idle_cycles = act ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int got;
    clear_pair_state();
    // directed sets
    point_queue.push_back(mk(-32768, 32767, 1'b1));
    point_queue.push_back(mk(-32768, -32768, 1'b0));
    point_queue.push_back(mk(32767, 32767, 1'b1));
    point_queue.push_back(mk(5, 5, 1'b0));
    point_queue.push_back(mk(5, 5, 1'b0));
    point_queue.push_back(mk(5, 5, 1'b1));
    for (int i = 0; i < 5; i++) point_queue.push_back(mk(7, 3 * i - 4, i == 4));
    add_set(6, -20, 20, 1'b1);
    point_queue.push_back(mk(0, 0, 1'b0));
    point_queue.push_back(mk(1, -1, 1'b0));
    point_queue.push_back(mk(3, 0, 1'b1));
    // random sets, mostly small, a few large
    got = 0;
    while (got < 620) begin
      int n, r;
      n = ($urandom_range(19) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 1);
      r = $urandom_range(3);
      if (r == 0) add_set(n, -32768, 32767, 1'b0);
      else if (r == 1) add_set(n, -40, 40, 1'b0);
      else if (r == 2) add_set(n, -2000, 2000, $urandom_range(9) == 0);
      else add_set(n, 32700, 32767, 1'b0);
      got += n;
    end
    n_total = point_queue.size();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (n_accepted == n_total && expected_answers.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_mismatch == 0 && expected_answers.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cpms_pkg.sv
sv/cpms_strip.sv
sv/closest_pair_merge_strip_top.sv
dv/tb.sv
